### rtl/core/ffa_pkg.sv
// shared types and constants of the first-fit free list allocator
package ffa_pkg;

  localparam int ADDR_W           = 16;
  localparam int STORE_DEPTH      = 65536;
  localparam int DEF_HEAP_UNITS   = 65536;
  localparam int DEF_HEADER_UNITS = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // one block header as held in the header memory
  typedef struct packed {
    logic              in_use;
    logic [ADDR_W-1:0] next;
    logic [ADDR_W-1:0] size;
  } hdr_t;

  // header memory access, one per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    hdr_t              wdata;
  } ram_req_t;

  // one result item
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } res_t;

endpackage

### rtl/core/first_fit_free_list_allocator.sv
// top level of the first-fit free list allocator
// Heap allocator with a first-fit free list held in one single-port header memory
// of 65536 entries. After reset the block runs a clearing pass, one header per
// cycle, with in_tready low; the whole heap then sits in one free block. An
// allocate walks the free list one header read per cycle: it is accepted, reads
// each free block it visits, writes one to three headers (remainder, granted
// block, predecessor link) and hands the result over; a walk that finds no fit
// hands over after its last list read. A free is accepted, checks the header
// and writes it back if in use, and hands over; zero-size requests, an empty
// list, null frees and out-of-range frees are answered straight after accept,
// with no header access. One item is worked on at a time; the output register
// lets the next item be accepted while a result waits to be taken.
module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int HEAP_UNITS   = DEF_HEAP_UNITS,
  parameter int HEADER_UNITS = DEF_HEADER_UNITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] alloc_size, [31:16] block_address
  input  logic        in_tuser,   // [0] cmd (0 allocate, 1 free)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] payload_address
  output logic [1:0]  out_tuser   // [1:0] status
);

  ram_req_t ram_req;
  hdr_t     ram_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic     out_valid_r;
  res_t     out_res_r;

  // header memory: in-use mark, next link, size per header offset
  ffa_hdr_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ffa_seq #(
    .HEAP_UNITS   (HEAP_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd_op    (in_tuser),
    .cmd_size  (in_tdata[15:0]),
    .cmd_addr  (in_tdata[31:16]),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: takes a result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.addr;
  assign out_tuser  = out_res_r.status;

endmodule

### rtl/core/ffa_hdr_ram.sv
// single-port header memory with registered read data
module ffa_hdr_ram import ffa_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output hdr_t     rdata
);

  hdr_t mem_r [0:STORE_DEPTH-1];
  hdr_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
    rdata_r <= mem_r[req.addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ffa_seq.sv
// command sequencer: clearing pass, list walk, split and unlink, free
module ffa_seq import ffa_pkg::*; #(
  parameter int HEAP_UNITS   = DEF_HEAP_UNITS,
  parameter int HEADER_UNITS = DEF_HEADER_UNITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic              cmd_op,
  input  logic [ADDR_W-1:0] cmd_size,
  input  logic [ADDR_W-1:0] cmd_addr,
  output ram_req_t          ram_req,
  input  hdr_t              ram_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int EFF_UNITS = (HEAP_UNITS > STORE_DEPTH) ? STORE_DEPTH : HEAP_UNITS;
  localparam logic [ADDR_W-1:0] HDR       = ADDR_W'(HEADER_UNITS);
  localparam logic [ADDR_W:0]   EFF_LIMIT = (ADDR_W + 1)'(EFF_UNITS);
  localparam logic [ADDR_W-1:0] RST_SIZE  = ADDR_W'(EFF_UNITS - HEADER_UNITS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ACHK, S_FCHK, S_WNH, S_WH, S_WPREV, S_RESP
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_idx_r;
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] cur_r;
  logic [ADDR_W-1:0] prev_r;
  hdr_t              prev_word_r;
  logic [ADDR_W-1:0] guard_r;
  logic [ADDR_W-1:0] nh_r;
  logic              split_r;
  logic [ADDR_W-1:0] newnext_r;
  logic [ADDR_W-1:0] hsize_r;
  logic [ADDR_W-1:0] nsize_r;
  logic [ADDR_W-1:0] hnext_r;
  res_t              res_r;

  logic [ADDR_W-1:0] surplus;
  logic              split_c;
  logic [ADDR_W-1:0] nh_c;
  logic              fit_c;

  // header index of a payload link
  function automatic logic [ADDR_W-1:0] hdr_of(input logic [ADDR_W-1:0] link);
    hdr_of = link - HDR;
  endfunction

  assign fit_c   = (ram_rdata.size >= req_r);
  assign surplus = ram_rdata.size - req_r;
  assign split_c = (surplus > HDR);
  assign nh_c    = cur_r + req_r;

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    ram_req = '0;
    case (state_r)
      S_CLEAR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = clr_idx_r;
        if (clr_idx_r == '0) begin
          ram_req.wdata.size = RST_SIZE;
        end
      end
      S_IDLE: begin
        ram_req.addr = (cmd_op == CMD_FREE) ? hdr_of(cmd_addr) : hdr_of(head_r);
      end
      S_ACHK: begin
        ram_req.addr = hdr_of(ram_rdata.next);
      end
      S_FCHK: begin
        ram_req.we           = ram_rdata.in_use;
        ram_req.addr         = hdr_of(addr_r);
        ram_req.wdata.in_use = 1'b0;
        ram_req.wdata.next   = head_r;
        ram_req.wdata.size   = ram_rdata.size;
      end
      S_WNH: begin
        ram_req.we           = 1'b1;
        ram_req.addr         = nh_r;
        ram_req.wdata.in_use = 1'b0;
        // the predecessor may sit on the new remainder header
        ram_req.wdata.next   = (prev_r != '0 && hdr_of(prev_r) == nh_r) ? newnext_r : hnext_r;
        ram_req.wdata.size   = nsize_r;
      end
      S_WH: begin
        ram_req.we           = 1'b1;
        ram_req.addr         = hdr_of(cur_r);
        ram_req.wdata.in_use = 1'b1;
        ram_req.wdata.next   = '0;
        ram_req.wdata.size   = hsize_r;
      end
      S_WPREV: begin
        ram_req.we           = 1'b1;
        ram_req.addr         = hdr_of(prev_r);
        ram_req.wdata.in_use = prev_word_r.in_use;
        ram_req.wdata.next   = newnext_r;
        ram_req.wdata.size   = prev_word_r.size;
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      head_r    <= HDR;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            res_r.addr <= '0;
            if (cmd_op == CMD_FREE) begin
              addr_r <= cmd_addr;
              if (cmd_addr == '0) begin
                res_r.status <= ST_OK;
                state_r      <= S_RESP;
              end else if (cmd_addr < HDR || {1'b0, cmd_addr} >= EFF_LIMIT) begin
                res_r.status <= ST_BADFREE;
                state_r      <= S_RESP;
              end else begin
                state_r <= S_FCHK;
              end
            end else begin
              req_r   <= cmd_size;
              cur_r   <= head_r;
              prev_r  <= '0;
              guard_r <= '0;
              if (cmd_size == '0) begin
                res_r.status <= ST_ZERO;
                state_r      <= S_RESP;
              end else if (head_r == '0) begin
                res_r.status <= ST_NOMEM;
                state_r      <= S_RESP;
              end else begin
                state_r <= S_ACHK;
              end
            end
          end
        end
        S_ACHK: begin
          if (fit_c) begin
            split_r <= split_c;
            nh_r    <= nh_c;
            hnext_r <= ram_rdata.next;
            nsize_r <= surplus - HDR;
            if (split_c) begin
              newnext_r <= nh_c + HDR;
              hsize_r   <= req_r;
              state_r   <= S_WNH;
            end else begin
              newnext_r <= ram_rdata.next;
              hsize_r   <= ram_rdata.size;
              state_r   <= S_WH;
            end
          end else begin
            prev_r      <= cur_r;
            prev_word_r <= ram_rdata;
            cur_r       <= ram_rdata.next;
            guard_r     <= guard_r + 1'b1;
            // end of list, or a walk as long as the whole store
            if (ram_rdata.next == '0 || guard_r == '1) begin
              res_r.addr   <= '0;
              res_r.status <= ST_NOMEM;
              state_r      <= S_RESP;
            end
          end
        end
        S_WNH: begin
          state_r <= S_WH;
        end
        S_WH: begin
          res_r.addr   <= cur_r;
          res_r.status <= ST_OK;
          if (prev_r == '0) begin
            head_r  <= newnext_r;
            state_r <= S_RESP;
          end else if (prev_r == cur_r || (split_r && hdr_of(prev_r) == nh_r)) begin
            state_r <= S_RESP;
          end else begin
            state_r <= S_WPREV;
          end
        end
        S_WPREV: begin
          state_r <= S_RESP;
        end
        S_FCHK: begin
          if (ram_rdata.in_use) begin
            head_r       <= addr_r;
            res_r.status <= ST_OK;
          end else begin
            res_r.status <= ST_BADFREE;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule

### rtl/core/ffa_checker.sv
// port-level checks of the allocator, bound to the top level
module ffa_checker import ffa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error result carries an address");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != '0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more items in flight than the block can hold");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);

### verif/ffa_checker.sv
// result checker with its own heap model for the first-fit allocator
module ffa_scoreboard import ffa_pkg::*; #(
  parameter int HEAP_UNITS   = DEF_HEAP_UNITS,
  parameter int HEADER_UNITS = DEF_HEADER_UNITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_SPAN = (HEAP_UNITS > STORE_DEPTH) ? STORE_DEPTH : HEAP_UNITS;

  // heap headers, indexed by header offset
  logic              hdr_used [STORE_DEPTH];
  logic [ADDR_W-1:0] hdr_next [STORE_DEPTH];
  logic [ADDR_W-1:0] hdr_size [STORE_DEPTH];
  int unsigned       list_head;

  res_t grant_q[$];
  res_t want;

  // header offset of a payload link
  function automatic logic [ADDR_W-1:0] hdr_at(int unsigned link);
    logic [ADDR_W-1:0] h;
    h = ADDR_W'(link - HEADER_UNITS);
    return h;
  endfunction

  // apply one command to the heap model and return the answer it gets
  function automatic res_t heap_step(logic cmd, logic [15:0] req, logic [15:0] ptr);
    res_t              r;
    int unsigned       prev, cur, hops, surplus, link_after;
    logic [ADDR_W-1:0] h, nh;
    logic              found;
    r.addr   = '0;
    r.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      if (req == '0) begin
        r.status = ST_ZERO;
      end else begin
        prev  = 0;
        cur   = list_head;
        hops  = 0;
        found = 1'b0;
        // first fit: stop at the first free block big enough
        while (!found && cur != 0 && hops < STORE_DEPTH) begin
          if (hdr_size[hdr_at(cur)] >= req) begin
            found = 1'b1;
          end else begin
            prev = cur;
            cur  = 32'(hdr_next[hdr_at(cur)]);
            hops++;
          end
        end
        if (!found) begin
          r.status = ST_NOMEM;
        end else begin
          h       = hdr_at(cur);
          surplus = 32'(hdr_size[h]) - 32'(req);
          if (surplus > HEADER_UNITS) begin
            // split, the remainder takes the old block's place in the list
            nh           = ADDR_W'(cur + req);
            hdr_used[nh] = 1'b0;
            hdr_size[nh] = ADDR_W'(surplus - HEADER_UNITS);
            hdr_next[nh] = hdr_next[h];
            hdr_size[h]  = req;
            link_after   = (32'(nh) + HEADER_UNITS) & 32'hFFFF;
          end else begin
            link_after = 32'(hdr_next[h]);
          end
          if (prev == 0) list_head = link_after;
          else hdr_next[hdr_at(prev)] = ADDR_W'(link_after);
          hdr_used[h] = 1'b1;
          hdr_next[h] = '0;
          r.addr      = ADDR_W'(cur);
        end
      end
    end else if (ptr != '0) begin
      if (ptr < HEADER_UNITS || ptr >= HEAP_SPAN || !hdr_used[hdr_at(ptr)]) begin
        r.status = ST_BADFREE;
      end else begin
        h           = hdr_at(ptr);
        hdr_used[h] = 1'b0;
        hdr_next[h] = ADDR_W'(list_head);
        list_head   = 32'(ptr);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        hdr_used[i] = 1'b0;
        hdr_next[i] = '0;
        hdr_size[i] = '0;
      end
      hdr_size[0] = ADDR_W'(HEAP_SPAN - HEADER_UNITS);
      list_head   = HEADER_UNITS;
      grant_q.delete();
    end else begin
      // check before queuing so a result never meets its own command
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, got addr %0d status %0d", $time,
                   out_tdata, out_tuser);
        end else begin
          want = grant_q.pop_front();
          if (out_tdata !== want.addr || out_tuser !== want.status) begin
            errors++;
            $display("%0t: mismatch, expected addr %0d status %0d, got addr %0d status %0d",
                     $time, want.addr, want.status, out_tdata, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready)
        grant_q.push_back(heap_step(in_tuser, in_tdata[15:0], in_tdata[31:16]));
    end
    pending = grant_q.size();
  end

endmodule

### verif/tb_top.sv
// top of the allocator testbench: clock, reset, command stimulus and verdict
module tb_top import ffa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_UNITS   = DEF_HEAP_UNITS;
  localparam int HEADER_UNITS = DEF_HEADER_UNITS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] alloc_size, [31:16] block_address
  logic        in_tuser = 1'b0; // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] payload_address
  logic [1:0]  out_tuser;       // [1:0] status

  int errors, pending;

  // idle odds in percent per cycle, and a long receiver hold-off in cycles
  int send_idle = 18;
  int recv_idle = 57;
  int hold_len  = 0;

  // payloads granted and not yet freed, and a few recently freed ones
  logic [15:0] live_q[$];
  logic [15:0] gone_q[$];

  always #2 clk = ~clk;

  first_fit_free_list_allocator #(
    .HEAP_UNITS  (HEAP_UNITS),
    .HEADER_UNITS(HEADER_UNITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ffa_scoreboard #(
    .HEAP_UNITS  (HEAP_UNITS),
    .HEADER_UNITS(HEADER_UNITS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver: a pending hold-off wins, else random back-pressure
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // granted payloads feed later frees
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser == ST_OK && out_tdata != '0)
      live_q.push_back(out_tdata);
  end

  // called at a falling edge, returns at the rising edge that takes the item
  task automatic offer(logic cmd, logic [15:0] req, logic [15:0] ptr);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ptr, req};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic issue(logic cmd, logic [15:0] req, logic [15:0] ptr);
    @(negedge clk);
    offer(cmd, req, ptr);
  endtask

  // mostly small allocations and frees of live blocks, plus some noise
  task automatic make_random(output logic cmd, output logic [15:0] req,
                             output logic [15:0] ptr);
    int pick, idx;
    req  = 16'($urandom);
    ptr  = 16'($urandom);
    pick = int'($urandom_range(99));
    if (live_q.size() == 0 || pick < 52) begin
      cmd  = CMD_ALLOC;
      pick = int'($urandom_range(99));
      if (pick < 4) req = '0;
      else if (pick < 70) req = 16'($urandom_range(64, 1));
      else if (pick < 93) req = 16'($urandom_range(4000, 65));
      else req = 16'($urandom_range(65535, 4001));
    end else begin
      cmd  = CMD_FREE;
      pick = int'($urandom_range(99));
      if (pick < 78) begin
        idx = int'($urandom_range(live_q.size() - 1));
        ptr = live_q[idx];
        live_q.delete(idx);
        gone_q.push_back(ptr);
        if (gone_q.size() > 16) void'(gone_q.pop_front());
      end else if (pick < 84 && gone_q.size() > 0) begin
        // double free, or a free of a block handed out again since
        ptr = gone_q[$urandom_range(gone_q.size() - 1)];
      end else if (pick < 88) begin
        ptr = '0;
      end else if (pick < 92) begin
        ptr = 16'($urandom_range(HEADER_UNITS - 1, 1));
      end
      // otherwise ptr stays a random offset, almost always a bad free
    end
  endtask

  task automatic send_random(int count);
    logic        cmd;
    logic [15:0] req, ptr;
    repeat (count) begin
      @(negedge clk);
      make_random(cmd, req, ptr);
      offer(cmd, req, ptr);
    end
  endtask

  // lower valid and let every outstanding result drain
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part; the first item waits out the header clearing pass
    issue(CMD_ALLOC, 16'd0, 16'd0);        // zero size
    issue(CMD_FREE, 16'd0, 16'd0);         // null free
    issue(CMD_FREE, 16'd0, 16'd1);         // below the first payload
    issue(CMD_FREE, 16'd0, 16'hFFFF);      // never allocated, top offset
    issue(CMD_FREE, 16'd0, 16'd2);         // free block, not in use
    issue(CMD_ALLOC, 16'hFFFF, 16'd0);     // larger than the heap
    issue(CMD_ALLOC, 16'd65534, 16'd0);    // exact fit of the whole heap
    issue(CMD_ALLOC, 16'd1, 16'd0);        // empty free list
    issue(CMD_FREE, 16'd0, 16'd2);
    issue(CMD_FREE, 16'd0, 16'd2);         // double free
    issue(CMD_ALLOC, 16'd65532, 16'd0);    // surplus of one header, no split
    issue(CMD_FREE, 16'd0, 16'd2);
    issue(CMD_ALLOC, 16'd65531, 16'd0);    // split leaves a one-unit tail block
    issue(CMD_ALLOC, 16'd1, 16'd0);        // takes the tail at the top payload
    issue(CMD_FREE, 16'd0, 16'hFFFF);
    issue(CMD_FREE, 16'd0, 16'd2);
    issue(CMD_ALLOC, 16'd40000, 16'd0);    // split at the list head
    issue(CMD_ALLOC, 16'd32768, 16'd0);    // walks the whole list, no fit
    issue(CMD_ALLOC, 16'd1, 16'd0);
    issue(CMD_FREE, 16'd0, 16'd2);
    issue(CMD_ALLOC, 16'd40000, 16'd0);    // refit into the freed block
    issue(CMD_FREE, 16'd0, 16'hFFFE);      // inside a payload, bad free
    drain();

    // sender idles less than the receiver
    send_random(150);
    hold_len = 400;                        // receiver stalls, block backs up
    send_random(40);
    drain();                               // sender pauses until all results are in
    send_random(110);

    // receiver fast, sender slow
    send_idle = 57;
    recv_idle = 18;
    send_random(300);

    // full rate both ways
    send_idle = 0;
    recv_idle = 0;
    send_random(300);

    drain();
    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // clearing pass plus ~900 items with long list walks fits well below this
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### sim.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_hdr_ram.sv
rtl/core/ffa_seq.sv
rtl/core/first_fit_free_list_allocator.sv
rtl/core/ffa_checker.sv
verif/ffa_checker.sv
verif/tb_top.sv
